@@ hdl/gbn_pkg.sv @@
package gbn_pkg;

  // Port widths fixed by the interface
  localparam int CMD_W      = 2;
  localparam int SEQ_PORT_W = 16;
  localparam int PAY_PORT_W = 64;
  localparam int WIN_W      = 4;

  // Longest resend run, and the width of a run count (holds MAX_OUT itself)
  localparam int MAX_OUT = 8;
  localparam int CNT_W   = 4;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Window size after reset
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

  // Commands
  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // Timer requests
  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } tmr_act_e;

endpackage

@@ hdl/go_back_n_sender_unit.sv @@
// Go-Back-N sender window. A result passes through the job queue, issue stage and output register.
// Throughput: one send, ack or idle command per cycle unless the queue is full or a run is busy.
// A timeout with n packets outstanding yields n results, one store read each;
// no further item is taken until the last resend read has been issued.
// Reset (rst_ni low, asynchronous): window empty, sequence numbers zero, window size 4,
// result side empty. The packet store is not cleared.
module go_back_n_sender_unit #(
  parameter int BUF_DEPTH    = 8,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  logic [gbn_pkg::CMD_W-1:0]          command_i,
  input  logic [gbn_pkg::PAY_PORT_W-1:0]     payload_i,
  input  logic [gbn_pkg::SEQ_PORT_W-1:0]     seq_number_i,
  input  logic                               checksum_ok_i,
  // window size register
  input  logic                               window_size_we_i,
  input  logic [gbn_pkg::WIN_W-1:0]          window_size_i,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic                               accepted_o,
  output logic                               packet_valid_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     packet_seq_o,
  output logic [gbn_pkg::PAY_PORT_W-1:0]     packet_data_o,
  output logic [1:0]                         timer_action_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     timer_stop_seq_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     timer_start_seq_o,
  output logic                               window_full_o,
  output logic                               last_o
);

  import gbn_pkg::*;

  localparam int SLOT_W = $clog2(BUF_DEPTH);

  // One job per accepted item. A plain job already holds its whole result;
  // a resend job holds the first sequence number, its ring slot and the run length.
  typedef struct packed {
    logic                    run;
    logic                    accepted;
    logic                    pkt_vld;
    logic [SEQ_BITS-1:0]     seq;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_BITS-1:0] data;
    logic [1:0]              tmr_act;
    logic [SEQ_BITS-1:0]     stop_seq;
    logic [SEQ_BITS-1:0]     start_seq;
    logic                    wfull;
    logic [CNT_W-1:0]        cnt;
  } job_t;

  job_t                    front_job, back_job;
  logic                    q_push, q_full, q_pop, q_empty, run_done;
  logic                    ram_we, ram_re;
  logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata, ram_rdata;

  // Front: classify the item, update base / next sequence / full flag at once,
  // write sent payloads into the ring and queue a job for the back end.
  gbn_front #(
    .BUF_DEPTH    (BUF_DEPTH),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .job_t        (job_t)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .command_i     (command_i),
    .payload_i     (payload_i),
    .seq_number_i  (seq_number_i),
    .checksum_ok_i (checksum_ok_i),
    .win_we_i      (window_size_we_i),
    .win_i         (window_size_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .job_o         (front_job),
    .run_done_i    (run_done),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  // Short job queue: lets the front keep taking items while results wait
  gbn_fifo #(
    .job_t (job_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (back_job),
    .empty_o (q_empty)
  );

  // Ring of sent payloads, slot = sequence number modulo BUF_DEPTH
  gbn_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Back: walk resend runs through the store one packet per cycle while results drain,
  // and hold each result in the output register until popped.
  gbn_back #(
    .BUF_DEPTH    (BUF_DEPTH),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .job_t        (job_t)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (back_job),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .run_done_o        (run_done),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .pop_i             (pop),
    .empty_o           (empty),
    .accepted_o        (accepted_o),
    .packet_valid_o    (packet_valid_o),
    .packet_seq_o      (packet_seq_o),
    .packet_data_o     (packet_data_o),
    .timer_action_o    (timer_action_o),
    .timer_stop_seq_o  (timer_stop_seq_o),
    .timer_start_seq_o (timer_start_seq_o),
    .window_full_o     (window_full_o),
    .last_o            (last_o)
  );

endmodule

@@ hdl/gbn_ram.sv @@
module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gbn_fifo.sv @@
module gbn_fifo #(
  parameter type job_t = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  import gbn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/gbn_front.sv @@
module gbn_front #(
  parameter int  BUF_DEPTH    = 8,
  parameter int  SEQ_BITS     = 16,
  parameter int  PAYLOAD_BITS = 64,
  parameter type job_t        = logic
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [gbn_pkg::CMD_W-1:0]          command_i,
  input  logic [gbn_pkg::PAY_PORT_W-1:0]     payload_i,
  input  logic [gbn_pkg::SEQ_PORT_W-1:0]     seq_number_i,
  input  logic                               checksum_ok_i,
  input  logic                               win_we_i,
  input  logic [gbn_pkg::WIN_W-1:0]          win_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output job_t                               job_o,
  input  logic                               run_done_i,
  output logic                               ram_we_o,
  output logic [$clog2(BUF_DEPTH)-1:0]       ram_waddr_o,
  output logic [PAYLOAD_BITS-1:0]            ram_wdata_o
);

  import gbn_pkg::*;

  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int SUM_W  = SLOT_W + CNT_W;
  localparam int CAP    = (BUF_DEPTH < MAX_OUT) ? BUF_DEPTH : MAX_OUT;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUF_DEPTH - 1);

  // Reduce a small sum into a ring slot
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    r = x;
    for (int k = 0; k < MAX_OUT / 2 + 1; k++) begin
      if (r >= SUM_W'(BUF_DEPTH)) begin
        r = r - SUM_W'(BUF_DEPTH);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  logic [SEQ_BITS-1:0] base_q, base_d, next_q, next_d;
  logic [SLOT_W-1:0]   base_slot_q, base_slot_d, next_slot_q, next_slot_d;
  logic                full_q, full_d;
  logic [WIN_W-1:0]    win_q;
  logic                busy_q;

  logic [WIN_W-1:0]    eff_win;
  logic [SEQ_BITS-1:0] eff_seq, fl, seq_in, off, nb, nfl;
  logic [CNT_W-1:0]    step;
  logic                accept, send_ok, run_push;
  job_t                job;

  always_comb begin
    if (win_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_q > WIN_W'(CAP)) begin
      eff_win = WIN_W'(CAP);
    end else begin
      eff_win = win_q;
    end
  end

  assign eff_seq = SEQ_BITS'(eff_win);
  assign fl      = next_q - base_q;
  assign seq_in  = SEQ_BITS'(seq_number_i);
  assign off     = seq_in - base_q;
  assign nb      = seq_in + 1'b1;
  assign nfl     = next_q - nb;
  assign step    = off[CNT_W-1:0] + 1'b1;

  // Stall input while the job queue is full or a resend run still has to read the store
  assign full_o = q_full_i || busy_q;
  assign accept = push_i && !full_o;

  always_comb begin
    job         = '0;
    job.wfull   = full_q;
    base_d      = base_q;
    next_d      = next_q;
    base_slot_d = base_slot_q;
    next_slot_d = next_slot_q;
    full_d      = full_q;
    send_ok     = 1'b0;
    run_push    = 1'b0;
    case (command_i)
      CMD_SEND: begin
        if (full_q || fl >= eff_seq) begin
          full_d    = 1'b1;
          job.wfull = 1'b1;
        end else begin
          send_ok     = 1'b1;
          next_d      = next_q + 1'b1;
          next_slot_d = (next_q == '1 || next_slot_q == SLOT_LAST) ? '0
                                                                   : next_slot_q + 1'b1;
          full_d      = (fl + 1'b1 >= eff_seq);
          job.accepted = 1'b1;
          job.pkt_vld  = 1'b1;
          job.seq      = next_q;
          job.data     = payload_i[PAYLOAD_BITS-1:0];
          job.wfull    = full_d;
          if (fl == '0) begin
            job.tmr_act   = TMR_START;
            job.start_seq = base_q;
          end
        end
      end
      CMD_ACK: begin
        if (checksum_ok_i && off < fl) begin
          base_d = nb;
          full_d = (nfl >= eff_seq);
          // advance the base slot; restart from the raw number on a sequence wrap
          if (nb < SEQ_BITS'(step)) begin
            base_slot_d = slot_mod(SUM_W'(nb[CNT_W-1:0]));
          end else begin
            base_slot_d = slot_mod(SUM_W'(base_slot_q) + SUM_W'(step));
          end
          job.accepted = 1'b1;
          job.stop_seq = base_q;
          job.wfull    = full_d;
          if (nfl != '0) begin
            job.tmr_act   = TMR_RESTART;
            job.start_seq = nb;
          end else begin
            job.tmr_act   = TMR_STOP;
          end
        end
      end
      CMD_TIMEOUT: begin
        job.stop_seq  = seq_in;
        job.start_seq = seq_in;
        job.tmr_act   = TMR_RESTART;
        if (fl != '0) begin
          run_push    = 1'b1;
          job.run     = 1'b1;
          job.pkt_vld = 1'b1;
          job.seq     = base_q;
          job.slot    = base_slot_q;
          job.cnt     = (fl > SEQ_BITS'(MAX_OUT)) ? CNT_W'(MAX_OUT) : fl[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign q_push_o    = accept;
  assign job_o       = job;
  assign ram_we_o    = accept && send_ok;
  assign ram_waddr_o = next_slot_q;
  assign ram_wdata_o = payload_i[PAYLOAD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      base_slot_q <= '0;
      next_slot_q <= '0;
      full_q      <= 1'b0;
      win_q       <= WIN_RESET;
      busy_q      <= 1'b0;
    end else begin
      if (win_we_i) begin
        win_q <= win_i;
      end
      if (accept) begin
        base_q      <= base_d;
        next_q      <= next_d;
        base_slot_q <= base_slot_d;
        next_slot_q <= next_slot_d;
        full_q      <= full_d;
      end
      if (run_done_i) begin
        busy_q <= 1'b0;
      end else if (accept && run_push) begin
        busy_q <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/gbn_back.sv @@
module gbn_back #(
  parameter int  BUF_DEPTH    = 8,
  parameter int  SEQ_BITS     = 16,
  parameter int  PAYLOAD_BITS = 64,
  parameter type job_t        = logic
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  job_t                               job_i,
  input  logic                               q_empty_i,
  output logic                               q_pop_o,
  output logic                               run_done_o,
  output logic                               ram_re_o,
  output logic [$clog2(BUF_DEPTH)-1:0]       ram_raddr_o,
  input  logic [PAYLOAD_BITS-1:0]            ram_rdata_i,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic                               accepted_o,
  output logic                               packet_valid_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     packet_seq_o,
  output logic [gbn_pkg::PAY_PORT_W-1:0]     packet_data_o,
  output logic [1:0]                         timer_action_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     timer_stop_seq_o,
  output logic [gbn_pkg::SEQ_PORT_W-1:0]     timer_start_seq_o,
  output logic                               window_full_o,
  output logic                               last_o
);

  import gbn_pkg::*;

  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUF_DEPTH - 1);

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot,
                                                  input logic [SEQ_BITS-1:0] seq);
    return (seq == '1 || slot == SLOT_LAST) ? '0 : slot + 1'b1;
  endfunction

  // resend run
  logic [CNT_W-1:0]    run_cnt_q, run_cnt_d;
  logic [SEQ_BITS-1:0] run_seq_q, run_seq_d;
  logic [SLOT_W-1:0]   run_slot_q, run_slot_d;
  logic                run_wfull_q, run_wfull_d;

  // issue stage (store read in flight)
  logic                    s1_vld_q, s1_ram_q, s1_acc_q, s1_pkt_q, s1_wfull_q, s1_last_q;
  logic [SEQ_BITS-1:0]     s1_seq_q, s1_stop_q, s1_start_q;
  logic [PAYLOAD_BITS-1:0] s1_data_q;
  logic [1:0]              s1_act_q;

  // output register
  logic                    out_vld_q, out_acc_q, out_pkt_q, out_wfull_q, out_last_q;
  logic [SEQ_PORT_W-1:0]   out_seq_q, out_stop_q, out_start_q;
  logic [PAY_PORT_W-1:0]   out_data_q;
  logic [1:0]              out_act_q;

  logic                    out_ready, s1_free, run_on, issue;
  logic                    iss_ram, iss_acc, iss_pkt, iss_wfull, iss_last;
  logic [SEQ_BITS-1:0]     iss_seq, iss_stop, iss_start;
  logic [SLOT_W-1:0]       iss_slot;
  logic [PAYLOAD_BITS-1:0] iss_data;
  logic [1:0]              iss_act;

  assign out_ready = !out_vld_q || pop_i;
  assign s1_free   = !s1_vld_q || out_ready;
  assign run_on    = (run_cnt_q != '0);
  assign issue     = s1_free && (run_on || !q_empty_i);
  assign q_pop_o   = s1_free && !run_on && !q_empty_i;

  always_comb begin
    run_cnt_d   = run_cnt_q;
    run_seq_d   = run_seq_q;
    run_slot_d  = run_slot_q;
    run_wfull_d = run_wfull_q;
    if (run_on) begin
      iss_ram   = 1'b1;
      iss_acc   = 1'b0;
      iss_pkt   = 1'b1;
      iss_seq   = run_seq_q;
      iss_slot  = run_slot_q;
      iss_data  = '0;
      iss_act   = TMR_NONE;
      iss_stop  = '0;
      iss_start = '0;
      iss_wfull = run_wfull_q;
      iss_last  = (run_cnt_q == CNT_W'(1));
      run_cnt_d  = run_cnt_q - 1'b1;
      run_seq_d  = run_seq_q + 1'b1;
      run_slot_d = slot_next(run_slot_q, run_seq_q);
    end else begin
      iss_ram   = job_i.run;
      iss_acc   = job_i.accepted;
      iss_pkt   = job_i.pkt_vld;
      iss_seq   = job_i.seq;
      iss_slot  = job_i.slot;
      iss_data  = job_i.data;
      iss_act   = job_i.tmr_act;
      iss_stop  = job_i.stop_seq;
      iss_start = job_i.start_seq;
      iss_wfull = job_i.wfull;
      iss_last  = !job_i.run || (job_i.cnt == CNT_W'(1));
      if (job_i.run) begin
        // first packet goes now, the rest of the run follows from here
        run_cnt_d   = job_i.cnt - 1'b1;
        run_seq_d   = job_i.seq + 1'b1;
        run_slot_d  = slot_next(job_i.slot, job_i.seq);
        run_wfull_d = job_i.wfull;
      end
    end
  end

  assign ram_re_o    = issue && iss_ram;
  assign ram_raddr_o = iss_slot;
  assign run_done_o  = issue && iss_ram && iss_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (issue) begin
        run_cnt_q <= run_cnt_d;
      end
      if (s1_free) begin
        s1_vld_q <= issue;
      end
      if (out_ready) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      run_seq_q   <= run_seq_d;
      run_slot_q  <= run_slot_d;
      run_wfull_q <= run_wfull_d;
      s1_ram_q    <= iss_ram;
      s1_acc_q    <= iss_acc;
      s1_pkt_q    <= iss_pkt;
      s1_seq_q    <= iss_seq;
      s1_data_q   <= iss_data;
      s1_act_q    <= iss_act;
      s1_stop_q   <= iss_stop;
      s1_start_q  <= iss_start;
      s1_wfull_q  <= iss_wfull;
      s1_last_q   <= iss_last;
    end
    if (s1_vld_q && out_ready) begin
      out_acc_q   <= s1_acc_q;
      out_pkt_q   <= s1_pkt_q;
      out_seq_q   <= SEQ_PORT_W'(s1_seq_q);
      out_data_q  <= PAY_PORT_W'(s1_ram_q ? ram_rdata_i : s1_data_q);
      out_act_q   <= s1_act_q;
      out_stop_q  <= SEQ_PORT_W'(s1_stop_q);
      out_start_q <= SEQ_PORT_W'(s1_start_q);
      out_wfull_q <= s1_wfull_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign empty_o           = !out_vld_q;
  assign accepted_o        = out_acc_q;
  assign packet_valid_o    = out_pkt_q;
  assign packet_seq_o      = out_seq_q;
  assign packet_data_o     = out_data_q;
  assign timer_action_o    = out_act_q;
  assign timer_stop_seq_o  = out_stop_q;
  assign timer_start_seq_o = out_start_q;
  assign window_full_o     = out_wfull_q;
  assign last_o            = out_last_q;

endmodule
